>>> sv/bfme_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfme_pkg
// Shared constants and types for the bit field move engine.
// ----------------------------------------------------------------------------
package bfme_pkg;

  localparam int MEM_BYTES  = 4096;
  localparam int ADDR_W     = $clog2(MEM_BYTES);
  localparam int TOTAL_BITS = MEM_BYTES * 8;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_MOVE  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  localparam logic STATUS_DONE  = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RDB,
    S_RDB_Q,
    S_RD_D,
    S_RD_S0,
    S_RD_S1,
    S_MERGE,
    S_DONE
  } state_t;

endpackage

>>> sv/bit_field_move_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bit_field_move_engine
// Byte memory with byte write, byte read and MSB-first bit run move.
// ----------------------------------------------------------------------------
// One item at a time. A byte write, a zero-length or out-of-range move, or a
// skipped item goes from acceptance straight to S_DONE, a byte read through
// S_RDB and S_RDB_Q first; out_valid is registered from S_DONE, and the next
// item can be taken in the cycle out_valid rises. A move works one
// destination byte at a time: it reads the destination byte and the two
// source bytes under it through the single read port of the memory, merges
// and writes back, in S_RD_D, S_RD_S0, S_RD_S1 and S_MERGE. The memory holds
// no reset value; bytes must be written before they are read. A result
// waiting on out_ready does not stop the next item from being accepted; the
// result of that next item then waits inside the block until the output
// register frees up.
// ----------------------------------------------------------------------------
module bit_field_move_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [11:0] in_byte_address,
  input  logic [7:0]  in_write_byte,
  input  logic [14:0] in_source_bit,
  input  logic [14:0] in_dest_bit,
  input  logic [15:0] in_bit_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_read_byte,
  output logic        out_status
);

  localparam int AW = bfme_pkg::ADDR_W;

  // byte store, one write port and one registered read port
  logic [7:0]    byte_mem_r [bfme_pkg::MEM_BYTES];
  logic [7:0]    mem_q_r;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;

  bfme_pkg::state_t state_r, state_nxt;

  // item context
  logic [AW-1:0] addr_r;
  logic [14:0]   dst_r;
  logic [16:0]   end_r;       // one past the last destination bit
  logic [AW-1:0] byte_r;      // destination byte in work
  logic [AW-1:0] last_byte_r;
  logic [15:0]   p0_r;        // source bit under bit 0 of byte_r (mod 2^16)
  logic [7:0]    d_r;         // destination byte as read
  logic [7:0]    s0_r;        // lower source byte
  logic [7:0]    res_rd_r;
  logic          res_st_r;

  logic          out_valid_r;
  logic [7:0]    out_read_byte_r;
  logic          out_status_r;

  // decode of the incoming item
  logic          accept;
  logic          addr_ok;
  logic [16:0]   src_end;
  logic [16:0]   dst_end;
  logic          cnt_zero;
  logic          over;
  logic          out_free;

  assign accept   = in_valid && in_ready;
  assign addr_ok  = 21'(in_byte_address) < 21'(bfme_pkg::MEM_BYTES);
  assign src_end  = 17'(in_source_bit) + 17'(in_bit_count);
  assign dst_end  = 17'(in_dest_bit) + 17'(in_bit_count);
  assign cnt_zero = (in_bit_count == 16'd0);
  assign over     = (src_end > 17'(bfme_pkg::TOTAL_BITS)) ||
                    (dst_end > 17'(bfme_pkg::TOTAL_BITS));
  assign out_free = !out_valid_r || out_ready;

  // source byte addresses for the current destination byte
  logic [AW-1:0] s0a;
  logic [AW-1:0] s1a;
  assign s0a = p0_r[AW+2:3];
  assign s1a = s0a + AW'(1);

  // Merge: bits are filled in ascending order. A source bit that falls in
  // the destination byte itself is taken from the partly built byte, which
  // reproduces the repeat pattern of an overlapping forward move.
  logic [7:0] merged;
  always_comb begin
    logic [15:0]   win;
    logic [3:0]    w;
    logic [AW-1:0] sel;
    logic [16:0]   q;
    logic          v;
    win    = {s0_r, mem_q_r};
    merged = d_r;
    for (int j = 0; j < 8; j++) begin
      q   = 17'({byte_r, 3'(j)});
      w   = 4'(p0_r[2:0]) + 4'(j);
      sel = w[3] ? s1a : s0a;
      if (sel == byte_r) begin
        v = merged[~w[2:0]];
      end else begin
        v = win[~w];
      end
      if ((q >= 17'(dst_r)) && (q < end_r)) begin
        merged[~3'(j)] = v;
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bfme_pkg::S_IDLE: begin
        if (accept) begin
          unique case (bfme_pkg::op_t'(in_operation))
            bfme_pkg::OP_READ: state_nxt = addr_ok ? bfme_pkg::S_RDB : bfme_pkg::S_DONE;
            bfme_pkg::OP_MOVE:
              state_nxt = (cnt_zero || over) ? bfme_pkg::S_DONE : bfme_pkg::S_RD_D;
            default: state_nxt = bfme_pkg::S_DONE;
          endcase
        end
      end
      bfme_pkg::S_RDB:   state_nxt = bfme_pkg::S_RDB_Q;
      bfme_pkg::S_RDB_Q: state_nxt = bfme_pkg::S_DONE;
      bfme_pkg::S_RD_D:  state_nxt = bfme_pkg::S_RD_S0;
      bfme_pkg::S_RD_S0: state_nxt = bfme_pkg::S_RD_S1;
      bfme_pkg::S_RD_S1: state_nxt = bfme_pkg::S_MERGE;
      bfme_pkg::S_MERGE:
        state_nxt = (byte_r == last_byte_r) ? bfme_pkg::S_DONE : bfme_pkg::S_RD_D;
      bfme_pkg::S_DONE:  if (out_free) state_nxt = bfme_pkg::S_IDLE;
      default:           state_nxt = bfme_pkg::S_IDLE;
    endcase
  end

  // control outputs: handshake, memory ports
  always_comb begin
    in_ready = 1'b0;
    rd_addr  = addr_r;
    wr_en    = 1'b0;
    wr_addr  = byte_r;
    wr_data  = merged;
    unique case (state_r)
      bfme_pkg::S_IDLE: begin
        in_ready = 1'b1;
        wr_addr  = AW'(in_byte_address);
        wr_data  = in_write_byte;
        wr_en    = in_valid && addr_ok &&
                   (bfme_pkg::op_t'(in_operation) == bfme_pkg::OP_WRITE);
      end
      bfme_pkg::S_RD_D:  rd_addr = byte_r;
      bfme_pkg::S_RD_S0: rd_addr = s0a;
      bfme_pkg::S_RD_S1: rd_addr = s1a;
      bfme_pkg::S_MERGE: wr_en   = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      byte_mem_r[wr_addr] <= wr_data;
    end
    mem_q_r <= byte_mem_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bfme_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      bfme_pkg::S_IDLE: begin
        if (accept) begin
          addr_r      <= AW'(in_byte_address);
          dst_r       <= in_dest_bit;
          end_r       <= dst_end;
          byte_r      <= in_dest_bit[AW+2:3];
          last_byte_r <= AW'((dst_end - 17'd1) >> 3);
          p0_r        <= 16'(in_source_bit) - 16'(in_dest_bit[2:0]);
          res_rd_r    <= 8'd0;
          unique case (bfme_pkg::op_t'(in_operation))
            bfme_pkg::OP_WRITE,
            bfme_pkg::OP_READ: res_st_r <= addr_ok ? bfme_pkg::STATUS_DONE
                                                   : bfme_pkg::STATUS_RANGE;
            bfme_pkg::OP_MOVE: res_st_r <= (!cnt_zero && over) ? bfme_pkg::STATUS_RANGE
                                                               : bfme_pkg::STATUS_DONE;
            default:           res_st_r <= bfme_pkg::STATUS_DONE;
          endcase
        end
      end
      bfme_pkg::S_RDB_Q: res_rd_r <= mem_q_r;
      bfme_pkg::S_RD_S0: d_r      <= mem_q_r;
      bfme_pkg::S_RD_S1: s0_r     <= mem_q_r;
      bfme_pkg::S_MERGE: begin
        byte_r <= byte_r + AW'(1);
        p0_r   <= p0_r + 16'd8;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == bfme_pkg::S_DONE) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == bfme_pkg::S_DONE) && out_free) begin
      out_read_byte_r <= res_rd_r;
      out_status_r    <= res_st_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_byte = out_read_byte_r;
  assign out_status    = out_status_r;

endmodule

>>> sv/bfme_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfme_checker
// Port-level checks for the bit field move engine, bound to the top level.
// ----------------------------------------------------------------------------
module bfme_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_read_byte,
  input logic        out_status
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_byte) && $stable(out_status))
    else $error("result changed while stalled");

  // a failed item never carries read data
  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_read_byte == 8'd0)
    else $error("read data on a failed item");

  // one item at a time: busy right after acceptance
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted two items back to back");

  // a result never shows up in the cycle right after acceptance
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result appeared too early");

endmodule

bind bit_field_move_engine bfme_checker u_bfme_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_read_byte (out_read_byte),
  .out_status    (out_status)
);

>>> sim/tb_bit_field_move_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bit_field_move_engine
// Self-checking bench for the bit field move engine. A shadow copy of the
// byte memory predicts every result. It tracks which bits hold written data,
// so the bench never reads a byte that still carries unwritten bits. Directed
// items cover the field extremes and the move corner cases. Random traffic,
// mostly kept inside a small working window, follows them with random
// idling on both channels, a long back-to-back stretch and a long stall
// on the result side.
// ----------------------------------------------------------------------------
module tb_bit_field_move_engine;

  // Most random traffic stays in the low 512 bytes so reads find data.
  localparam int HOT_BYTES     = 512;
  localparam int HOT_BITS      = HOT_BYTES * 8;
  localparam int IDLE_PCT      = 16;
  localparam int HOLD_CYCLES   = 400;
  // A full-memory move runs long with no handshake at all.
  localparam int STALL_LIMIT   = 100000;
  localparam int SETTLE_CYCLES = 50;

  typedef struct {
    bfme_pkg::op_t op;
    logic [11:0]   addr;
    logic [7:0]    wdata;
    logic [14:0]   src;
    logic [14:0]   dst;
    logic [15:0]   cnt;
  } bfm_cmd_t;

  typedef struct {
    logic [7:0] rbyte;
    logic       status;
  } bfm_reply_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_operation;
  logic [11:0] in_byte_address;
  logic [7:0]  in_write_byte;
  logic [14:0] in_source_bit;
  logic [14:0] in_dest_bit;
  logic [15:0] in_bit_count;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_read_byte;
  logic        out_status;

  // Shadow memory and a per-bit mark of which bits hold written data.
  // Mask bits sit at the same positions as the data bits.
  bit [7:0]   byte_image   [0:bfme_pkg::MEM_BYTES-1];
  bit [7:0]   written_mask [0:bfme_pkg::MEM_BYTES-1];
  int         written_addrs[$];
  bfm_reply_t pending_replies[$];

  int fail_count   = 0;
  int quiet_cycles = 0;
  bit steady       = 1'b0;  // no idling on either side while set
  bit hold_request = 1'b0;  // asks the receiver for one long stall

  bit_field_move_engine dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_byte_address (in_byte_address),
    .in_write_byte   (in_write_byte),
    .in_source_bit   (in_source_bit),
    .in_dest_bit     (in_dest_bit),
    .in_bit_count    (in_bit_count),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_read_byte   (out_read_byte),
    .out_status      (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Prediction: apply one accepted item to the shadow memory, return the
  // result it must produce.
  // --------------------------------------------------------------------------
  function automatic bfm_reply_t run_item_on_image(bfm_cmd_t c);
    bfm_reply_t  r;
    int unsigned first_src;
    int unsigned first_dst;
    int unsigned n;
    int unsigned k;
    int unsigned sp;
    int unsigned dp;
    r.rbyte  = 8'h00;
    r.status = bfme_pkg::STATUS_DONE;
    case (c.op)
      bfme_pkg::OP_WRITE: begin
        if (c.addr < bfme_pkg::MEM_BYTES) begin
          byte_image[c.addr]   = c.wdata;
          written_mask[c.addr] = 8'hff;
          written_addrs.push_back(int'(c.addr));
        end else begin
          r.status = bfme_pkg::STATUS_RANGE;
        end
      end
      bfme_pkg::OP_READ: begin
        if (c.addr < bfme_pkg::MEM_BYTES) r.rbyte = byte_image[c.addr];
        else r.status = bfme_pkg::STATUS_RANGE;
      end
      bfme_pkg::OP_MOVE: begin
        first_src = c.src;
        first_dst = c.dst;
        n         = c.cnt;
        // zero length never flags, whatever the offsets
        if (n != 0) begin
          if (first_src + n > bfme_pkg::TOTAL_BITS ||
              first_dst + n > bfme_pkg::TOTAL_BITS) begin
            r.status = bfme_pkg::STATUS_RANGE;
          end else begin
            // ascending bit order: a forward overlap repeats the pattern
            for (k = 0; k < n; k++) begin
              sp = first_src + k;
              dp = first_dst + k;
              byte_image[dp >> 3][7 - (dp & 7)] = byte_image[sp >> 3][7 - (sp & 7)];
              written_mask[dp >> 3][7 - (dp & 7)] =
                written_mask[sp >> 3][7 - (sp & 7)];
            end
          end
        end
      end
      default: ;  // unused code: no effect
    endcase
    return r;
  endfunction

  function automatic bfm_cmd_t make_cmd(bfme_pkg::op_t op, logic [11:0] addr,
                                        logic [7:0] wdata,
                                        logic [14:0] src, logic [14:0] dst,
                                        logic [15:0] cnt);
    bfm_cmd_t c;
    c.op    = op;
    c.addr  = addr;
    c.wdata = wdata;
    c.src   = src;
    c.dst   = dst;
    c.cnt   = cnt;
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Random item. Fields unused by the operation still get full-range noise.
  // --------------------------------------------------------------------------
  function automatic bfm_cmd_t draw_item();
    bfm_cmd_t c;
    int       pick;
    int       span;
    int       tries;
    int       idx;
    int       base;
    bit       found;
    c.op    = bfme_pkg::OP_NONE;
    c.addr  = 12'($urandom_range(0, 4095));
    c.wdata = 8'($urandom_range(0, 255));
    c.src   = 15'($urandom_range(0, 32767));
    c.dst   = 15'($urandom_range(0, 32767));
    c.cnt   = 16'($urandom_range(0, 65535));
    found   = 1'b0;
    idx     = 0;
    pick    = $urandom_range(0, 99);
    if (pick < 60 && pick >= 30) begin
      // read only bytes whose every bit has been written
      for (tries = 0; tries < 8 && !found && written_addrs.size() > 0; tries++) begin
        idx = written_addrs[$urandom_range(0, written_addrs.size() - 1)];
        if (written_mask[idx] == 8'hff) found = 1'b1;
      end
      if (found) begin
        c.op   = bfme_pkg::OP_READ;
        c.addr = 12'(idx);
      end else begin
        pick = 0;  // nothing readable yet: write instead
      end
    end
    if (pick < 30) begin
      c.op = bfme_pkg::OP_WRITE;
      if ($urandom_range(0, 99) < 70) c.addr = 12'($urandom_range(0, HOT_BYTES - 1));
    end else if (pick >= 60 && pick < 95) begin
      // well-formed move that starts inside the working window
      c.op = bfme_pkg::OP_MOVE;
      span = $urandom_range(0, 99);
      if (span < 80)      c.cnt = 16'($urandom_range(1, 64));
      else if (span < 95) c.cnt = 16'($urandom_range(65, 600));
      else                c.cnt = 16'($urandom_range(601, 4000));
      c.src = 15'($urandom_range(0, HOT_BITS - 1));
      if ($urandom_range(0, 99) < 40) begin
        // close overlap in either direction
        base = int'(c.src) + int'($urandom_range(0, 40)) - 20;
        if (base < 0) base = 0;
        if (base > HOT_BITS - 1) base = HOT_BITS - 1;
        c.dst = 15'(base);
      end else begin
        c.dst = 15'($urandom_range(0, HOT_BITS - 1));
      end
    end else if (pick >= 95) begin
      // noise: unused code, raw random move, zero-length move
      case ($urandom_range(0, 2))
        0:       c.op = bfme_pkg::OP_NONE;
        1:       c.op = bfme_pkg::OP_MOVE;
        default: begin
          c.op  = bfme_pkg::OP_MOVE;
          c.cnt = 16'h0000;
        end
      endcase
    end
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Sender side. Called at a clock edge; returns at the edge that took the
  // item. Valid stays high across back-to-back items.
  // --------------------------------------------------------------------------
  task automatic send_item(bfm_cmd_t c);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_operation    <= c.op;
    in_byte_address <= c.addr;
    in_write_byte   <= c.wdata;
    in_source_bit   <= c.src;
    in_dest_bit     <= c.dst;
    in_bit_count    <= c.cnt;
    do @(posedge clk); while (!in_ready);
    pending_replies.push_back(run_item_on_image(c));
  endtask

  // sender pauses until every outstanding result is back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_byte_access();
    send_item(make_cmd(bfme_pkg::OP_WRITE, 12'd0,    8'h80, 15'h0000, 15'h0000, 16'h0000));
    send_item(make_cmd(bfme_pkg::OP_WRITE, 12'd1,    8'h7f, 15'h7fff, 15'h7fff, 16'hffff));
    send_item(make_cmd(bfme_pkg::OP_WRITE, 12'd2,    8'hfe, 15'h0000, 15'h0000, 16'h0000));
    send_item(make_cmd(bfme_pkg::OP_WRITE, 12'd3,    8'hff, 15'h0000, 15'h0000, 16'h0000));
    send_item(make_cmd(bfme_pkg::OP_WRITE, 12'd4,    8'h00, 15'h0000, 15'h0000, 16'h0000));
    send_item(make_cmd(bfme_pkg::OP_WRITE, 12'd4095, 8'h01, 15'h0000, 15'h0000, 16'h0000));
    send_item(make_cmd(bfme_pkg::OP_READ,  12'd0,    8'hff, 15'h0000, 15'h0000, 16'h0000));
    send_item(make_cmd(bfme_pkg::OP_READ,  12'd4095, 8'h00, 15'h7fff, 15'h7fff, 16'hffff));
    // unused code with every field at its top
    send_item(make_cmd(bfme_pkg::OP_NONE,  12'd4095, 8'hff, 15'h7fff, 15'h7fff, 16'hffff));
    wait_for_results();
  endtask

  task automatic test_bit_moves();
    // unaligned, byte 6 fully covered
    send_item(make_cmd(bfme_pkg::OP_MOVE, 12'd0, 8'h00, 15'd9,  15'd43, 16'd13));
    send_item(make_cmd(bfme_pkg::OP_READ, 12'd6, 8'h00, 15'd0,  15'd0,  16'd0));
    // forward overlap: pattern repeats every 3 bits
    send_item(make_cmd(bfme_pkg::OP_MOVE, 12'd0, 8'h00, 15'd8,  15'd11, 16'd29));
    send_item(make_cmd(bfme_pkg::OP_READ, 12'd2, 8'h00, 15'd0,  15'd0,  16'd0));
    // backward overlap
    send_item(make_cmd(bfme_pkg::OP_MOVE, 12'd0, 8'h00, 15'd20, 15'd17, 16'd16));
    // last bit of memory as source
    send_item(make_cmd(bfme_pkg::OP_MOVE, 12'd0, 8'h00, 15'd32767, 15'd0, 16'd1));
    send_item(make_cmd(bfme_pkg::OP_READ, 12'd0, 8'h00, 15'd0,  15'd0,  16'd0));
    // destination ends exactly at the top of memory
    send_item(make_cmd(bfme_pkg::OP_MOVE, 12'd0, 8'h00, 15'd0,  15'd32760, 16'd8));
    send_item(make_cmd(bfme_pkg::OP_READ, 12'd4095, 8'h00, 15'd0, 15'd0, 16'd0));
    // zero length with offsets at the top: no flag
    send_item(make_cmd(bfme_pkg::OP_MOVE, 12'd0, 8'h00, 15'd32767, 15'd32767, 16'd0));
    // range errors: source end, destination end, huge count
    send_item(make_cmd(bfme_pkg::OP_MOVE, 12'd0, 8'h00, 15'd32767, 15'd0, 16'd2));
    send_item(make_cmd(bfme_pkg::OP_MOVE, 12'd0, 8'h00, 15'd0, 15'd32761, 16'd8));
    send_item(make_cmd(bfme_pkg::OP_MOVE, 12'd0, 8'h00, 15'd0, 15'd0, 16'hffff));
    // whole memory onto itself
    send_item(make_cmd(bfme_pkg::OP_MOVE, 12'd0, 8'h00, 15'd0, 15'd0, 16'd32768));
    wait_for_results();
  endtask

  task automatic test_random_traffic(int n);
    repeat (n) send_item(draw_item());
    wait_for_results();
  endtask

  task automatic test_steady_stream(int n);
    steady = 1'b1;
    repeat (n) send_item(draw_item());
    wait_for_results();
    steady = 1'b0;
  endtask

  // receiver stalls for a long stretch while items keep coming
  task automatic test_output_backpressure();
    hold_request = 1'b1;
    repeat (12) send_item(draw_item());
    wait_for_results();
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random ready, or one long stall on request.
  // --------------------------------------------------------------------------
  initial begin : receiver
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: in order, field by field.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_replies
    bfm_reply_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_replies.size() == 0) begin
        $error("result with no item outstanding: read_byte %02h status %0b",
               out_read_byte, out_status);
        fail_count++;
      end else begin
        want = pending_replies.pop_front();
        if (out_read_byte !== want.rbyte) begin
          $error("read_byte mismatch: expected %02h, actual %02h",
                 want.rbyte, out_read_byte);
          fail_count++;
        end
        if (out_status !== want.status) begin
          $error("status mismatch: expected %0b, actual %0b", want.status, out_status);
          fail_count++;
        end
      end
    end
  end

  // watchdog: cycles with no handshake on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_operation    <= bfme_pkg::OP_NONE;
    in_byte_address <= '0;
    in_write_byte   <= '0;
    in_source_bit   <= '0;
    in_dest_bit     <= '0;
    in_bit_count    <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_byte_access();
    test_bit_moves();
    test_random_traffic(650);
    test_steady_stream(250);
    test_output_backpressure();
    test_random_traffic(650);

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_replies.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
